@@ hw/rtl/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] RD_POP   = 2'd0;
    localparam logic [1:0] RD_FRONT = 2'd1;
    localparam logic [1:0] RD_BACK  = 2'd2;

    typedef struct packed {
        logic             load;
        logic [1:0]       rd_sel;
        logic             update;
        logic             commit;
        logic [ST_W-1:0]  status;
        logic             lat_front;
    } t_dp_cmd;

    typedef struct packed {
        logic             is_pop;
        logic             empty;
        logic             full;
    } t_dp_stat;

endpackage

@@ hw/rtl/deq_ram.sv @@
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/deq_ctrl.sv @@
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_valid,
    input  deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_RDF  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       legal;

    assign legal = i_stat.is_pop ? !i_stat.empty : !i_stat.full;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = deq_pkg::RD_POP;
        o_cmd.status    = deq_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_POP;
                end
            end
            S_POP: begin
                o_cmd.rd_sel = deq_pkg::RD_POP;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                o_cmd.commit = legal;
                if (!legal) begin
                    o_cmd.status = i_stat.is_pop ? deq_pkg::ST_EMPTY : deq_pkg::ST_FULL;
                end
                n_state = S_RDF;
            end
            S_RDF: begin
                o_cmd.rd_sel = deq_pkg::RD_FRONT;
                n_state      = S_RDB;
            end
            S_RDB: begin
                o_cmd.lat_front = 1'b1;
                o_cmd.rd_sel    = deq_pkg::RD_BACK;
                n_state         = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

@@ hw/rtl/deq_datapath.sv @@
`timescale 1ns / 1ps

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [deq_pkg::OP_W-1:0]            i_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_data_value,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    output deq_pkg::t_dp_stat                   o_stat,
    output logic signed [deq_pkg::WORD_W-1:0]   o_popped_value,
    output logic [deq_pkg::ST_W-1:0]            o_status,
    output logic [deq_pkg::CNT_OUT_W-1:0]       o_entry_count,
    output logic signed [deq_pkg::WORD_W-1:0]   o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]   o_back_value
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [deq_pkg::OP_W-1:0]   r_op;
    logic [deq_pkg::WORD_W-1:0] r_data;
    logic [AW-1:0]              r_head;
    logic [CW-1:0]              r_count;
    logic [deq_pkg::WORD_W-1:0] r_popped;
    logic [deq_pkg::ST_W-1:0]   r_status;
    logic [deq_pkg::WORD_W-1:0] r_front;

    logic [AW-1:0]              back_pos;
    logic [AW-1:0]              tail_pos;
    logic [AW-1:0]              prev_head;
    logic [AW-1:0]              next_head;
    logic [AW-1:0]              raddr;
    logic [AW-1:0]              waddr;
    logic                       we;
    logic [deq_pkg::WORD_W-1:0] rdata;
    logic                       is_pop;
    logic [CW+deq_pkg::CNT_OUT_W-1:0] cnt_ext;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    assign is_pop    = (r_op == deq_pkg::OP_POP_FRONT) || (r_op == deq_pkg::OP_POP_BACK);
    assign back_pos  = ring_add(r_head, r_count - CW'(1));
    assign tail_pos  = ring_add(r_head, r_count);
    assign prev_head = ring_add(r_head, DEPTH_C - CW'(1));
    assign next_head = ring_add(r_head, CW'(1));

    assign o_stat.is_pop = is_pop;
    assign o_stat.empty  = (r_count == '0);
    assign o_stat.full   = (r_count == DEPTH_C);

    always_comb begin
        case (i_cmd.rd_sel)
            deq_pkg::RD_POP:   raddr = (r_op == deq_pkg::OP_POP_BACK) ? back_pos : r_head;
            deq_pkg::RD_FRONT: raddr = r_head;
            deq_pkg::RD_BACK:  raddr = back_pos;
            default:           raddr = r_head;
        endcase
    end

    assign we    = i_cmd.update && i_cmd.commit && !is_pop;
    assign waddr = (r_op == deq_pkg::OP_PUSH_FRONT) ? prev_head : tail_pos;

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_data <= i_data_value;
        end
        if (i_cmd.update) begin
            r_popped <= (i_cmd.commit && is_pop) ? rdata : '0;
            r_status <= i_cmd.status;
        end
        if (i_cmd.lat_front) begin
            r_front <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.update && i_cmd.commit) begin
            case (r_op)
                deq_pkg::OP_PUSH_FRONT: begin
                    r_head  <= prev_head;
                    r_count <= r_count + CW'(1);
                end
                deq_pkg::OP_PUSH_BACK: begin
                    r_count <= r_count + CW'(1);
                end
                deq_pkg::OP_POP_FRONT: begin
                    r_head  <= next_head;
                    r_count <= r_count - CW'(1);
                end
                default: begin
                    r_count <= r_count - CW'(1);
                end
            endcase
        end
    end

    assign cnt_ext        = {{deq_pkg::CNT_OUT_W{1'b0}}, r_count};
    assign o_entry_count  = cnt_ext[deq_pkg::CNT_OUT_W-1:0];
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_front_value  = (r_count != '0) ? r_front : '0;
    assign o_back_value   = (r_count != '0) ? rdata : '0;

endmodule

@@ hw/rtl/double_ended_queue_core.sv @@
`timescale 1ns / 1ps

// Channel   Handshake             Ports
// -------   ---------             -----
// op in     start & !busy         i_opcode, i_data_value
// result    o_valid (one cycle)   o_popped_value, o_status, o_entry_count,
//                                 o_front_value, o_back_value
//
// Operations do not overlap: the single
// RAM read port is used in turn for the popped word, the front and the back.
// The result is shown in the done state, after the pop, update, front-read and back-read states, for one cycle.
// Synchronous active-low reset empties the queue; the store itself is not cleared.
// The receiver cannot stall; busy stays high until the result has been shown.

module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [deq_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0] i_data_value,
    output logic                              o_valid,
    output logic signed [deq_pkg::WORD_W-1:0] o_popped_value,
    output logic [deq_pkg::ST_W-1:0]          o_status,
    output logic [deq_pkg::CNT_OUT_W-1:0]     o_entry_count,
    output logic signed [deq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0] o_back_value
);

    deq_pkg::t_dp_cmd  cmd;
    deq_pkg::t_dp_stat stat;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_data_value   (i_data_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

endmodule

@@ hw/rtl/deq_checker.sv @@
`timescale 1ns / 1ps

module deq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [deq_pkg::WORD_W-1:0] o_popped_value,
    input logic [deq_pkg::ST_W-1:0]          o_status,
    input logic [deq_pkg::CNT_OUT_W-1:0]     o_entry_count,
    input logic signed [deq_pkg::WORD_W-1:0] o_front_value,
    input logic signed [deq_pkg::WORD_W-1:0] o_back_value
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##5 o_valid)
        else $error("result not shown five cycles after accept");

    a_result_ends_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe not followed by idle");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_entry_count == '0) |-> (o_front_value == '0) && (o_back_value == '0))
        else $error("front or back word nonzero on empty queue");

    a_error_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != deq_pkg::ST_OK) |-> (o_popped_value == '0))
        else $error("popped word nonzero on failed operation");

endmodule

bind double_ended_queue_core deq_checker u_chk (.*);
